@@ hdl/lavm_pkg.sv @@
// Package for the look-at view matrix block: transaction types and shared constants.
// No dependencies.
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_hint_x;
        logic signed [31:0] up_hint_y;
        logic signed [31:0] up_hint_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
        logic               degenerate;
        logic               last_row;
    } out_item_t;

    // Work item handed from the front part to the back part.
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [32:0] dir_x;
        logic signed [32:0] dir_y;
        logic signed [32:0] dir_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } work_t;

endpackage

@@ hdl/look_at_view_matrix.sv @@
// Top level of the look-at view matrix block.
// Depends on lavm_pkg, lavm_front and lavm_back.
//
// Usage: push an input transaction (eye, target, up hint, signed fixed point)
// while full is low. Each input transaction yields four row transactions,
// rows 0 to 3 in order, last_row set on row 3. A row is shown while empty is
// low and is taken with pop.
// A two-entry queue in the front part holds inputs while the back sequencer
// works, so new inputs are taken while rows still wait to be popped.
// In the back part each item runs three normalizations (less work when a vector
// is degenerate), each with a 32-step square root, three 64-step bit-serial
// divisions and one bit of prescaling per cycle; these dominate the latency and
// set the throughput, and the back part takes no new item until it has emitted its last row.
// Reset empties the queue and the output register; no rows are pending.
// When the receiver stops popping, the output register holds its row, the
// back part waits, and full rises once the queue fills.
module look_at_view_matrix #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lavm_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output lavm_pkg::out_item_t out_item
);
    import lavm_pkg::*;

    logic  wk_valid, wk_take;
    work_t wk_item;

    lavm_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .wk_valid(wk_valid), .wk_take(wk_take), .wk_item(wk_item)
    );

    lavm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .wk_valid(wk_valid), .wk_take(wk_take),
        .wk_item(wk_item), .empty(empty), .pop(pop), .out_item(out_item)
    );
endmodule

@@ hdl/lavm_front.sv @@
// Front part: accepts input transactions, forms eye minus target and queues the work.
// Depends on lavm_pkg.
module lavm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lavm_pkg::in_item_t in_item,
    output logic               wk_valid,
    input  logic               wk_take,
    output lavm_pkg::work_t    wk_item
);
    import lavm_pkg::*;

    work_t     q_mem [QUEUE_DEPTH];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    work_t     w;
    logic      do_push, do_pop;

    always_comb
    begin
        w.eye_x = in_item.eye_x;
        w.eye_y = in_item.eye_y;
        w.eye_z = in_item.eye_z;
        w.dir_x = 33'(in_item.eye_x) - 33'(in_item.target_x);
        w.dir_y = 33'(in_item.eye_y) - 33'(in_item.target_y);
        w.dir_z = 33'(in_item.eye_z) - 33'(in_item.target_z);
        w.up_x  = in_item.up_hint_x;
        w.up_y  = in_item.up_hint_y;
        w.up_z  = in_item.up_hint_z;
    end

    assign full     = (count_reg == 2'(QUEUE_DEPTH));
    assign wk_valid = (count_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = wk_take && wk_valid;
    assign wk_item  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

@@ hdl/lavm_back.sv @@
// Back part: sequencer that normalizes, forms cross products and translations,
// and emits four rows through an output register. Depends on lavm_pkg.
module lavm_back #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wk_valid,
    output logic                wk_take,
    input  lavm_pkg::work_t     wk_item,
    output logic                empty,
    input  logic                pop,
    output lavm_pkg::out_item_t out_item
);
    import lavm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ABS, S_SCALE, S_SQ, S_SUM, S_SQRT, S_DIV, S_NEXT,
        S_CROSS_MUL, S_CROSS_SUB, S_DOT_MUL, S_DOT_SUM, S_ROUND, S_EMIT
    } state_t;

    state_t state_reg;
    work_t  wk_reg;
    logic [1:0] pass_reg;      // 0 forward, 1 side, 2 true up
    logic [1:0] idx_reg;       // component or row index
    logic signed [64:0] vec_reg [3];
    logic [63:0] mag_reg [3];
    logic [63:0] sq_reg [3];
    logic [63:0] rad_reg, res_reg, bit_reg, len_reg;
    logic [63:0] num_reg, quo_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic signed [31:0] fwd_reg [3];
    logic signed [31:0] side_reg [3];
    logic signed [31:0] tup_reg [3];
    logic signed [31:0] trn_reg [3];
    logic signed [63:0] prod_reg [3];
    logic signed [66:0] dsum_reg;
    logic signed [64:0] p_reg [2];
    logic deg_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic [63:0] mx;
    logic [63:0] rtry;
    logic [63:0] rsh;
    logic signed [66:0] dsum;
    logic signed [66:0] nsum;
    logic [66:0] dmag;
    logic [66:0] rnd;
    logic signed [31:0] trn_val;
    logic signed [31:0] qs;
    logic signed [31:0] a0, a1, b0, b1;

    assign wk_take  = (state_reg == S_IDLE) && wk_valid;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
        rtry = res_reg + bit_reg;
        rsh  = (num_reg << 1) | 64'(quo_reg[63]);
        dsum = 67'(prod_reg[0]) + 67'(prod_reg[1]) + 67'(prod_reg[2]);
        nsum = -dsum_reg;
        dmag = nsum[66] ? 67'(-nsum) : 67'(nsum);
        rnd  = (dmag + (67'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (nsum[66])
            trn_val = (rnd > 67'h80000000) ? 32'sh80000000 : 32'(-rnd);
        else
            trn_val = (rnd > 67'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(rnd);
        qs = vec_reg[idx_reg][64] ? 32'(-quo_reg) : 32'(quo_reg);
        // Cross product operand selection: side = up x fwd, true up = fwd x side.
        unique case (idx_reg)
            2'd0:    begin a0 = 1; b0 = 2; a1 = 2; b1 = 1; end
            2'd1:    begin a0 = 2; b0 = 0; a1 = 0; b1 = 2; end
            default: begin a0 = 0; b0 = 1; a1 = 1; b1 = 0; end
        endcase
    end

    function automatic logic signed [31:0] sel_a(input logic [1:0] p, input logic [1:0] i,
            input logic signed [31:0] u0, input logic signed [31:0] u1,
            input logic signed [31:0] u2, input logic signed [31:0] f0,
            input logic signed [31:0] f1, input logic signed [31:0] f2);
        logic signed [31:0] r;
        begin
            if (p == 2'd1)
                r = (i == 2'd0) ? u0 : (i == 2'd1) ? u1 : u2;
            else
                r = (i == 2'd0) ? f0 : (i == 2'd1) ? f1 : f2;
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pass_reg      <= 2'd0;
            idx_reg       <= 2'd0;
            deg_reg       <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (wk_valid)
                    begin
                        wk_reg     <= wk_item;
                        vec_reg[0] <= 65'(wk_item.dir_x);
                        vec_reg[1] <= 65'(wk_item.dir_y);
                        vec_reg[2] <= 65'(wk_item.dir_z);
                        pass_reg   <= 2'd0;
                        deg_reg    <= 1'b0;
                        state_reg  <= S_ABS;
                    end
                end
                S_ABS:
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= vec_reg[i][64] ? 64'(-vec_reg[i]) : 64'(vec_reg[i]);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    // One bit of scaling per cycle until the largest lies in [2^29, 2^30).
                    if (mx == 64'd0)
                    begin
                        deg_reg <= 1'b1;
                        quo_reg <= 64'd0;
                        idx_reg <= 2'd0;
                        for (int i = 0; i < 3; i++) vec_reg[i] <= '0;
                        state_reg <= S_NEXT;
                    end
                    else if (mx >= (64'd1 << 30))
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    else if (mx < (64'd1 << 29))
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    else
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    for (int i = 0; i < 3; i++)
                        sq_reg[i] <= mag_reg[i][31:0] * mag_reg[i][31:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    rad_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    res_reg   <= 64'd0;
                    bit_reg   <= 64'd1 << 62;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg == 64'd0)
                    begin
                        len_reg   <= res_reg;
                        idx_reg   <= 2'd0;
                        quo_reg   <= (mag_reg[0] << FRAC_BITS) + (res_reg >> 1);
                        num_reg   <= 64'd0;
                        cnt_reg   <= 7'd64;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (rad_reg >= rtry)
                        begin
                            rad_reg <= rad_reg - rtry;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (cnt_reg == 7'd0)
                        state_reg <= S_NEXT;
                    else
                    begin
                        if (rsh >= len_reg)
                        begin
                            num_reg <= rsh - len_reg;
                            quo_reg <= (quo_reg << 1) | 64'd1;
                        end
                        else
                        begin
                            num_reg <= rsh;
                            quo_reg <= quo_reg << 1;
                        end
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_NEXT:
                begin
                    unique case (pass_reg)
                        2'd0:    fwd_reg[idx_reg]  <= qs;
                        2'd1:    side_reg[idx_reg] <= qs;
                        default: tup_reg[idx_reg]  <= qs;
                    endcase
                    if (idx_reg != 2'd2)
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        quo_reg   <= (mag_reg[idx_reg + 2'd1] << FRAC_BITS) + (len_reg >> 1);
                        num_reg   <= 64'd0;
                        cnt_reg   <= 7'd64;
                        state_reg <= S_DIV;
                        if (vec_reg[0] == '0 && vec_reg[1] == '0 && vec_reg[2] == '0)
                        begin
                            quo_reg   <= 64'd0;
                            state_reg <= S_NEXT;
                        end
                    end
                    else
                    begin
                        idx_reg <= 2'd0;
                        if (pass_reg == 2'd2)
                            state_reg <= S_DOT_MUL;
                        else
                            state_reg <= S_CROSS_MUL;
                    end
                end
                S_CROSS_MUL:
                begin
                    p_reg[0] <= 65'(sel_a(pass_reg + 2'd1, 2'(a0), wk_reg.up_x, wk_reg.up_y,
                        wk_reg.up_z, fwd_reg[0], fwd_reg[1], fwd_reg[2])
                        * sel_a(2'd0, 2'(b0), side_reg[0], side_reg[1], side_reg[2],
                        (pass_reg == 2'd0) ? fwd_reg[0] : side_reg[0],
                        (pass_reg == 2'd0) ? fwd_reg[1] : side_reg[1],
                        (pass_reg == 2'd0) ? fwd_reg[2] : side_reg[2]));
                    p_reg[1] <= 65'(sel_a(pass_reg + 2'd1, 2'(a1), wk_reg.up_x, wk_reg.up_y,
                        wk_reg.up_z, fwd_reg[0], fwd_reg[1], fwd_reg[2])
                        * sel_a(2'd0, 2'(b1), side_reg[0], side_reg[1], side_reg[2],
                        (pass_reg == 2'd0) ? fwd_reg[0] : side_reg[0],
                        (pass_reg == 2'd0) ? fwd_reg[1] : side_reg[1],
                        (pass_reg == 2'd0) ? fwd_reg[2] : side_reg[2]));
                    state_reg <= S_CROSS_SUB;
                end
                S_CROSS_SUB:
                begin
                    vec_reg[idx_reg] <= p_reg[0] - p_reg[1];
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= 2'd0;
                        pass_reg  <= pass_reg + 2'd1;
                        state_reg <= S_ABS;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_CROSS_MUL;
                    end
                end
                S_DOT_MUL:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        logic signed [31:0] ax, ev;
                        ax = (idx_reg == 2'd0) ? side_reg[i] :
                             (idx_reg == 2'd1) ? tup_reg[i] : fwd_reg[i];
                        ev = (i == 0) ? wk_reg.eye_x : (i == 1) ? wk_reg.eye_y : wk_reg.eye_z;
                        prod_reg[i] <= ax * ev;
                    end
                    state_reg <= S_DOT_SUM;
                end
                S_DOT_SUM:
                begin
                    dsum_reg  <= dsum;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    trn_reg[idx_reg] <= trn_val;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= 2'd0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_DOT_MUL;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.row_index  <= idx_reg;
                        out_reg.degenerate <= deg_reg;
                        out_reg.last_row   <= (idx_reg == 2'd3);
                        if (idx_reg == 2'd3)
                        begin
                            out_reg.elem_0 <= trn_reg[0];
                            out_reg.elem_1 <= trn_reg[1];
                            out_reg.elem_2 <= trn_reg[2];
                            out_reg.elem_3 <= 32'sd1 <<< FRAC_BITS;
                            idx_reg        <= 2'd0;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            out_reg.elem_0 <= side_reg[idx_reg];
                            out_reg.elem_1 <= tup_reg[idx_reg];
                            out_reg.elem_2 <= fwd_reg[idx_reg];
                            out_reg.elem_3 <= 32'sd0;
                            idx_reg        <= idx_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
